FILE: design/ppm_frame_decoder_macros.svh
// Assertion macros for the PPM frame decoder.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef PPM_FRAME_DECODER_MACROS_SVH
`define PPM_FRAME_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every clock edge outside reset.
`define PPMFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define PPMFD_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`else

`define PPMFD_ASSERT(lbl, prop, msg)
`define PPMFD_ASSERT_NEXT(lbl, trig, cons, msg)

`endif

`endif

FILE: design/ppmfd_pkg.sv
package ppmfd_pkg;

  localparam int STAMP_W   = 16;
  localparam int VALUE_W   = 14;
  localparam int CHAN_W    = 4;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam int DEFAULT_NUM_CHANNELS = 8;

  localparam logic [STAMP_W-1:0] SYNC_GAP_MIN_RST = 16'd20000;
  localparam logic [STAMP_W-1:0] PULSE_MIN_RST    = 16'd3000;
  localparam logic [STAMP_W-1:0] PULSE_MAX_RST    = 16'd9000;
  localparam logic [VALUE_W-1:0] OUT_LOW_RST      = 14'd1000;
  localparam logic [VALUE_W-1:0] OUT_HIGH_RST     = 14'd2000;

  typedef enum logic [2:0] {
    REG_SYNC_GAP_MIN = 3'd0,
    REG_PULSE_MIN    = 3'd1,
    REG_PULSE_MAX    = 3'd2,
    REG_OUT_LOW      = 3'd3,
    REG_OUT_HIGH     = 3'd4
  } ppmfd_reg_e;

  typedef enum logic {
    KIND_CAPTURE = 1'b0,
    KIND_READ    = 1'b1
  } ppmfd_kind_e;

  typedef struct packed {
    logic [STAMP_W-1:0] sync_gap_min;
    logic [STAMP_W-1:0] pulse_min;
    logic [STAMP_W-1:0] pulse_max;
    logic [VALUE_W-1:0] out_low;
    logic [VALUE_W-1:0] out_high;
  } ppmfd_cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  stored_channel;
    logic [STAMP_W-1:0] stored_width;
    logic [VALUE_W-1:0] channel_value;
    logic               link_ok;
  } ppmfd_result_t;

endpackage

FILE: design/ppmfd_cfg_regs.sv
module ppmfd_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ppmfd_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ppmfd_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ppmfd_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready,
  output ppmfd_pkg::ppmfd_cfg_t               cfg_o
);

  ppmfd_pkg::ppmfd_cfg_t cfg_q, cfg_d;
  logic [2:0]            reg_idx;
  logic                  wr_en;

  // Registers sit on word boundaries; the two low address bits are ignored.
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        ppmfd_pkg::REG_SYNC_GAP_MIN: cfg_d.sync_gap_min = pwdata[ppmfd_pkg::STAMP_W-1:0];
        ppmfd_pkg::REG_PULSE_MIN:    cfg_d.pulse_min    = pwdata[ppmfd_pkg::STAMP_W-1:0];
        ppmfd_pkg::REG_PULSE_MAX:    cfg_d.pulse_max    = pwdata[ppmfd_pkg::STAMP_W-1:0];
        ppmfd_pkg::REG_OUT_LOW:      cfg_d.out_low      = pwdata[ppmfd_pkg::VALUE_W-1:0];
        ppmfd_pkg::REG_OUT_HIGH:     cfg_d.out_high     = pwdata[ppmfd_pkg::VALUE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ppmfd_pkg::REG_SYNC_GAP_MIN: prdata = ppmfd_pkg::APB_DATA_W'(cfg_q.sync_gap_min);
      ppmfd_pkg::REG_PULSE_MIN:    prdata = ppmfd_pkg::APB_DATA_W'(cfg_q.pulse_min);
      ppmfd_pkg::REG_PULSE_MAX:    prdata = ppmfd_pkg::APB_DATA_W'(cfg_q.pulse_max);
      ppmfd_pkg::REG_OUT_LOW:      prdata = ppmfd_pkg::APB_DATA_W'(cfg_q.out_low);
      ppmfd_pkg::REG_OUT_HIGH:     prdata = ppmfd_pkg::APB_DATA_W'(cfg_q.out_high);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_gap_min <= ppmfd_pkg::SYNC_GAP_MIN_RST;
      cfg_q.pulse_min    <= ppmfd_pkg::PULSE_MIN_RST;
      cfg_q.pulse_max    <= ppmfd_pkg::PULSE_MAX_RST;
      cfg_q.out_low      <= ppmfd_pkg::OUT_LOW_RST;
      cfg_q.out_high     <= ppmfd_pkg::OUT_HIGH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/ppmfd_core.sv
module ppmfd_core #(
  parameter int NUM_CHANNELS = ppmfd_pkg::DEFAULT_NUM_CHANNELS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ppmfd_pkg::ppmfd_cfg_t             cfg_i,
  input  logic                              fire_i,
  input  logic                              kind_i,
  input  logic [ppmfd_pkg::STAMP_W-1:0]     capture_time_i,
  input  logic [ppmfd_pkg::CHAN_W-1:0]      read_channel_i,
  output ppmfd_pkg::ppmfd_result_t          result_o,
  output logic                              link_ok_o
);

  // Position runs from 0 up to one past the last channel.
  localparam int PosW = $clog2(NUM_CHANNELS + 2);

  logic [ppmfd_pkg::STAMP_W-1:0] last_stamp_q, last_stamp_d;
  logic [PosW-1:0]               pos_q, pos_d, pos_base;
  logic                          frame_good_q, frame_good_d;
  logic [ppmfd_pkg::STAMP_W-1:0] store_q [NUM_CHANNELS];
  logic [ppmfd_pkg::STAMP_W-1:0] store_d [NUM_CHANNELS];

  logic [ppmfd_pkg::STAMP_W-1:0] gap;
  logic                          is_capture;
  logic                          is_sync;
  logic                          pos_in_range;
  logic                          in_window;
  logic                          do_store;
  logic [PosW-1:0]               stored_ch;
  logic                          read_hit;
  logic [ppmfd_pkg::STAMP_W-1:0] read_width;
  logic [ppmfd_pkg::VALUE_W-1:0] scaled;
  logic [ppmfd_pkg::VALUE_W-1:0] clamped;

  assign is_capture   = fire_i && (kind_i == ppmfd_pkg::KIND_CAPTURE);
  assign gap          = capture_time_i - last_stamp_q;
  assign is_sync      = gap > cfg_i.sync_gap_min;
  assign pos_in_range = (pos_q != '0) && (pos_q <= PosW'(NUM_CHANNELS));
  assign in_window    = (gap > cfg_i.pulse_min) && (gap < cfg_i.pulse_max);
  assign do_store     = !is_sync && pos_in_range && in_window;
  assign stored_ch    = do_store ? pos_q : '0;

  always_comb begin
    frame_good_d = frame_good_q;
    pos_base     = pos_q;
    if (is_sync) begin
      pos_base = '0;
    end else if (pos_in_range) begin
      if (in_window) begin
        if (pos_q == PosW'(NUM_CHANNELS)) begin
          frame_good_d = 1'b1;
        end
      end else begin
        frame_good_d = 1'b0;
      end
    end else begin
      frame_good_d = 1'b0;
      pos_base     = '0;
    end
    pos_d        = PosW'(pos_base + 1'b1);
    last_stamp_d = capture_time_i;
  end

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      store_d[i] = (do_store && (pos_q == PosW'(i + 1))) ? gap : store_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_stamp_q <= '0;
      pos_q        <= '0;
      frame_good_q <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        store_q[i] <= '0;
      end
    end else if (is_capture) begin
      last_stamp_q <= last_stamp_d;
      pos_q        <= pos_d;
      frame_good_q <= frame_good_d;
      store_q      <= store_d;
    end
  end

  // Channel read: select the stored width, drop two bits, clamp.
  always_comb begin
    read_hit   = 1'b0;
    read_width = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (int'(read_channel_i) == i + 1) begin
        read_hit   = 1'b1;
        read_width = store_q[i];
      end
    end
  end

  assign scaled = read_width[ppmfd_pkg::STAMP_W-1:2];

  always_comb begin
    if (scaled < cfg_i.out_low) begin
      clamped = cfg_i.out_low;
    end else if (scaled > cfg_i.out_high) begin
      clamped = cfg_i.out_high;
    end else begin
      clamped = scaled;
    end
  end

  always_comb begin
    if (kind_i == ppmfd_pkg::KIND_CAPTURE) begin
      result_o.stored_channel = ppmfd_pkg::CHAN_W'(stored_ch);
      result_o.stored_width   = gap;
      result_o.channel_value  = '0;
      result_o.link_ok        = frame_good_d;
    end else begin
      result_o.stored_channel = '0;
      result_o.stored_width   = '0;
      result_o.channel_value  = read_hit ? clamped : '0;
      result_o.link_ok        = frame_good_q;
    end
  end

  assign link_ok_o = frame_good_q;

endmodule

FILE: design/ppm_frame_decoder.sv
// PPM frame decoder. Each input beat is either a capture stamp from a 16-bit
// free-running timer or a request to read one channel. A capture measures the
// gap to the previous stamp (modulo 2^16); a gap above sync_gap_min marks a
// frame sync, and gaps at channel positions 1 to NUM_CHANNELS that lie
// strictly between pulse_min and pulse_max are stored, the last one setting
// link OK. A read returns the stored width shifted right by two and clamped
// to out_low and out_high. Every input beat yields exactly one result beat.
// The block takes one beat per clock cycle while its output is not stalled;
// each beat passes through the input register and then the result register.
// The rate is set by the decode loop: the stamp subtract, the window compares
// and the position update are combinational in front of the state registers,
// so that the next capture already sees the updated state. Configuration sits
// behind an APB port with registers at byte addresses 0, 4, 8, 12 and 16; it
// should only be written while no beat is in flight.
module ppm_frame_decoder #(
  parameter int NUM_CHANNELS = ppmfd_pkg::DEFAULT_NUM_CHANNELS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ppmfd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ppmfd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ppmfd_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready,
  // Input channel.
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             kind_i,
  input  logic [ppmfd_pkg::STAMP_W-1:0]    capture_time_i,
  input  logic [ppmfd_pkg::CHAN_W-1:0]     read_channel_i,
  // Output channel.
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [ppmfd_pkg::CHAN_W-1:0]     stored_channel_o,
  output logic [ppmfd_pkg::STAMP_W-1:0]    stored_width_o,
  output logic [ppmfd_pkg::VALUE_W-1:0]    channel_value_o,
  output logic                             link_ok_o
);

`include "ppm_frame_decoder_macros.svh"

  ppmfd_pkg::ppmfd_cfg_t    cfg;
  ppmfd_pkg::ppmfd_result_t core_res;
  ppmfd_pkg::ppmfd_result_t out_q;
  logic                     link_state;

  logic                          in_valid_q;
  logic                          in_kind_q;
  logic [ppmfd_pkg::STAMP_W-1:0] in_time_q;
  logic [ppmfd_pkg::CHAN_W-1:0]  in_chan_q;
  logic                          out_valid_q;

  logic advance;
  logic fire;
  logic load;

  ppmfd_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The result register moves on whenever it is empty or being taken.
  // The held input beat is processed in the same cycle it moves into it.
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (load) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      in_kind_q <= kind_i;
      in_time_q <= capture_time_i;
      in_chan_q <= read_channel_i;
    end
  end

  ppmfd_core #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .fire_i         (fire),
    .kind_i         (in_kind_q),
    .capture_time_i (in_time_q),
    .read_channel_i (in_chan_q),
    .result_o       (core_res),
    .link_ok_o      (link_state)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= core_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stored_channel_o = out_q.stored_channel;
  assign stored_width_o   = out_q.stored_width;
  assign channel_value_o  = out_q.channel_value;
  assign link_ok_o        = out_q.link_ok;

  // The input side only stalls while both stages hold a beat.
  `PPMFD_ASSERT(a_stall_only_when_full, in_stall_o |-> (in_valid_q && out_valid_q), "input stalled with a free stage")
  // A processed beat always lands in the result register.
  `PPMFD_ASSERT_NEXT(a_result_follows_fire, fire, out_valid_q, "processed beat did not reach the result register")
  // Link OK can only come up through a capture.
  `PPMFD_ASSERT(a_link_rises_on_capture, $rose(link_state) |-> $past(fire && (in_kind_q == ppmfd_pkg::KIND_CAPTURE)), "link OK rose without a capture")
  // A read result never reports a stored channel or width.
  `PPMFD_ASSERT(a_read_result_clean, (out_valid_q && (out_q.channel_value != '0)) |-> ((out_q.stored_channel == '0) && (out_q.stored_width == '0)), "read result carries capture fields")

endmodule

FILE: sim/tb_ppm_frame_decoder.sv
module tb_ppm_frame_decoder;
  import ppmfd_pkg::*;

  localparam int NUM_CH          = DEFAULT_NUM_CHANNELS;
  // Cycles without any accepted beat on either channel before the run is declared hung.
  localparam int QUIET_LIMIT     = 2000;
  // Long receiver hold-off, long enough to back the block up into its input.
  localparam int HOLD_OFF_CYCLES = 300;
  // Margin waited out after the last pending result has come back.
  localparam int SETTLE_CYCLES   = 6;
  localparam int NUM_DIRECTED    = 22;

  // One row of the directed table. When typed is set, res is the result written
  // down by hand; otherwise the result comes from the decoder model below.
  typedef struct packed {
    logic               kind;
    logic [STAMP_W-1:0] stamp;
    logic [CHAN_W-1:0]  chan;
    logic               typed;
    ppmfd_result_t      res;
  } dir_row_t;

  // The table runs on reset thresholds: sync above 20000, window (3000, 9000),
  // clamp [1000, 2000]. It walks reads of untouched channels, reads outside
  // 1..8, an edge at position 0, a sync, window edges on both sides, a timer
  // wrap, a full frame that raises link OK, an edge beyond the last channel, a
  // gap of all ones and a capture stamp of all ones.
  localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{KIND_READ,    16'd0,     4'd1,  1'b1, '{4'd0, 16'd0,     14'd1000, 1'b0}},
    '{KIND_READ,    16'd0,     4'd0,  1'b1, '{4'd0, 16'd0,     14'd0,    1'b0}},
    '{KIND_READ,    16'hFFFF,  4'd15, 1'b1, '{4'd0, 16'd0,     14'd0,    1'b0}},
    '{KIND_CAPTURE, 16'd0,     4'd0,  1'b1, '{4'd0, 16'd0,     14'd0,    1'b0}},
    '{KIND_CAPTURE, 16'd30000, 4'd0,  1'b1, '{4'd0, 16'd30000, 14'd0,    1'b0}},
    '{KIND_CAPTURE, 16'd33001, 4'd0,  1'b1, '{4'd1, 16'd3001,  14'd0,    1'b0}},
    '{KIND_CAPTURE, 16'd42000, 4'd0,  1'b1, '{4'd2, 16'd8999,  14'd0,    1'b0}},
    '{KIND_CAPTURE, 16'd45000, 4'd15, 1'b1, '{4'd0, 16'd3000,  14'd0,    1'b0}},
    '{KIND_CAPTURE, 16'd54000, 4'd0,  1'b1, '{4'd0, 16'd9000,  14'd0,    1'b0}},
    '{KIND_CAPTURE, 16'd58000, 4'd0,  1'b1, '{4'd5, 16'd4000,  14'd0,    1'b0}},
    '{KIND_CAPTURE, 16'd63000, 4'd0,  1'b1, '{4'd6, 16'd5000,  14'd0,    1'b0}},
    '{KIND_CAPTURE, 16'd3464,  4'd0,  1'b0, '0},
    '{KIND_CAPTURE, 16'd11464, 4'd0,  1'b1, '{4'd8, 16'd8000,  14'd0,    1'b1}},
    '{KIND_READ,    16'd0,     4'd1,  1'b1, '{4'd0, 16'd0,     14'd1000, 1'b1}},
    '{KIND_READ,    16'd0,     4'd2,  1'b1, '{4'd0, 16'd0,     14'd2000, 1'b1}},
    '{KIND_READ,    16'd0,     4'd6,  1'b0, '0},
    '{KIND_READ,    16'd0,     4'd3,  1'b1, '{4'd0, 16'd0,     14'd1000, 1'b1}},
    '{KIND_CAPTURE, 16'd31464, 4'd0,  1'b1, '{4'd0, 16'd20000, 14'd0,    1'b0}},
    '{KIND_CAPTURE, 16'd51465, 4'd0,  1'b1, '{4'd0, 16'd20001, 14'd0,    1'b0}},
    '{KIND_CAPTURE, 16'd51464, 4'd0,  1'b1, '{4'd0, 16'd65535, 14'd0,    1'b0}},
    '{KIND_READ,    16'd0,     4'd8,  1'b0, '0},
    '{KIND_CAPTURE, 16'hFFFF,  4'd0,  1'b1, '{4'd0, 16'd14071, 14'd0,    1'b0}}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  kind_i;
  logic [STAMP_W-1:0]    capture_time_i;
  logic [CHAN_W-1:0]     read_channel_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [CHAN_W-1:0]     stored_channel_o;
  logic [STAMP_W-1:0]    stored_width_o;
  logic [VALUE_W-1:0]    channel_value_o;
  logic                  link_ok_o;

  // Sideband that travels with the input payload: a hand-written result for
  // directed rows. It is driven together with the payload so the monitor sees
  // the value that belongs to the beat accepted at a given edge.
  logic                  beat_typed;
  ppmfd_result_t         beat_typed_res;

  // Decoder model: thresholds and the frame state as the block should hold them.
  ppmfd_cfg_t            thresholds;
  logic [STAMP_W-1:0]    prev_stamp;
  logic [CHAN_W-1:0]     frame_pos;
  logic [STAMP_W-1:0]    width_store [1:NUM_CH];
  logic                  link_good;

  ppmfd_result_t         pending_results [$];

  logic [STAMP_W-1:0]    stamp_now;    // last capture stamp sent
  int                    beats_sent;
  int                    quiet_cycles;
  int                    hold_off;     // set by the stimulus, consumed by the receiver
  bit                    no_idle;
  bit                    failed;

  ppm_frame_decoder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .capture_time_i   (capture_time_i),
    .read_channel_i   (read_channel_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .stored_channel_o (stored_channel_o),
    .stored_width_o   (stored_width_o),
    .channel_value_o  (channel_value_o),
    .link_ok_o        (link_ok_o)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Works out the result of one accepted beat and advances the frame state.
  // A capture measures the gap modulo 2^16: a gap above the sync threshold
  // restarts the count, a gap inside the window at positions 1..NUM_CH is
  // stored (the last one raises link OK), a gap outside the window drops link
  // OK, and an edge at position 0 or past the last channel drops link OK and
  // restarts the count. A read scales the stored width down by four and
  // clamps it; a value between crossed clamps takes the low clamp.
  function automatic ppmfd_result_t decode_beat(input logic kind,
                                                input logic [STAMP_W-1:0] stamp,
                                                input logic [CHAN_W-1:0] chan);
    ppmfd_result_t      res;
    logic [STAMP_W-1:0] gap;
    logic [VALUE_W-1:0] scaled;
    res = '0;
    if (kind == KIND_CAPTURE) begin
      gap = stamp - prev_stamp;
      res.stored_width = gap;
      if (gap > thresholds.sync_gap_min) begin
        frame_pos = '0;
      end else if (frame_pos >= 1 && frame_pos <= NUM_CH) begin
        if (gap > thresholds.pulse_min && gap < thresholds.pulse_max) begin
          width_store[frame_pos] = gap;
          res.stored_channel = frame_pos;
          if (frame_pos == NUM_CH) link_good = 1'b1;
        end else begin
          link_good = 1'b0;
        end
      end else begin
        link_good = 1'b0;
        frame_pos = '0;
      end
      prev_stamp = stamp;
      frame_pos = frame_pos + 1'b1;
    end else if (chan >= 1 && chan <= NUM_CH) begin
      scaled = VALUE_W'(width_store[chan] >> 2);
      if (scaled < thresholds.out_low) res.channel_value = thresholds.out_low;
      else if (scaled > thresholds.out_high) res.channel_value = thresholds.out_high;
      else res.channel_value = scaled;
    end
    res.link_ok = link_good;
    return res;
  endfunction

  task automatic check_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
      failed = 1'b1;
    end
  endtask

  // Monitor on both channels plus the hang watchdog. The input side is
  // handled first so that a beat's expectation is queued before any result
  // on the same edge is matched.
  always @(posedge clk_i) begin
    ppmfd_result_t due;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      due = decode_beat(kind_i, capture_time_i, read_channel_i);
      pending_results.push_back(beat_typed ? beat_typed_res : due);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with no pending expectation", $time);
        failed = 1'b1;
      end else begin
        due = pending_results.pop_front();
        check_field("stored_channel", int'(due.stored_channel), int'(stored_channel_o));
        check_field("stored_width", int'(due.stored_width), int'(stored_width_o));
        check_field("channel_value", int'(due.channel_value), int'(channel_value_o));
        check_field("link_ok", int'(due.link_ok), int'(link_ok_o));
      end
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result receiver. It draws a random stall, possibly none, for every beat; a
  // hold-off request from the stimulus replaces one draw with a long stall.
  initial begin
    int stall_cycles;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (hold_off > 0) stall_cycles = hold_off;
      else stall_cycles = no_idle ? 0 : $urandom_range(0, 4);
      hold_off = 0;
      if (stall_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Offers one input beat after a random gap and returns at the edge where
  // it is taken. Valid stays high into the next beat when that gap is zero.
  task automatic send_beat(input logic kind, input logic [STAMP_W-1:0] stamp,
                           input logic [CHAN_W-1:0] chan, input logic typed,
                           input ppmfd_result_t typed_res);
    int gap_cycles;
    gap_cycles = no_idle ? 0 : $urandom_range(0, 4);
    if (gap_cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap_cycles) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    capture_time_i <= stamp;
    read_channel_i <= chan;
    beat_typed     <= typed;
    beat_typed_res <= typed_res;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_capture(input logic [STAMP_W-1:0] gap);
    stamp_now = stamp_now + gap;
    send_beat(KIND_CAPTURE, stamp_now, CHAN_W'($urandom_range(0, 15)), 1'b0, '0);
    beats_sent++;
  endtask

  // Reads mostly target real channels, with the odd out-of-range number.
  task automatic send_read();
    logic [CHAN_W-1:0] chan;
    if ($urandom_range(0, 9) == 0) chan = CHAN_W'($urandom_range(0, 15));
    else chan = CHAN_W'($urandom_range(1, NUM_CH));
    send_beat(KIND_READ, STAMP_W'($urandom_range(0, 65535)), chan, 1'b0, '0);
    beats_sent++;
  endtask

  // A gap that reads as frame sync under the current thresholds, if one exists.
  function automatic logic [STAMP_W-1:0] sync_gap();
    if (thresholds.sync_gap_min < 16'hFFFF)
      return STAMP_W'($urandom_range(thresholds.sync_gap_min + 1, 65535));
    return STAMP_W'($urandom_range(0, 65535));
  endfunction

  // A gap strictly inside the pulse window, if the window is open at all.
  function automatic logic [STAMP_W-1:0] window_gap();
    if (thresholds.pulse_max > thresholds.pulse_min + 1)
      return STAMP_W'($urandom_range(thresholds.pulse_min + 1, thresholds.pulse_max - 1));
    return STAMP_W'($urandom_range(0, 65535));
  endfunction

  // Random traffic. Most of it is complete frames (sync then one gap per
  // channel, reads sprinkled in), so that the store and link OK paths are
  // exercised; the rest is random-length frames with at most one bad gap, and noise.
  task automatic run_traffic(input int n_beats);
    int target;
    int pick;
    int n_ch;
    int bad_at;
    target = beats_sent + n_beats;
    while (beats_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_capture(sync_gap());
        for (int c = 1; c <= NUM_CH; c++) begin
          send_capture(window_gap());
          if ($urandom_range(0, 3) == 0) send_read();
        end
      end else if (pick < 85) begin
        n_ch   = $urandom_range(0, NUM_CH + 2);
        bad_at = $urandom_range(1, NUM_CH + 4);
        send_capture(sync_gap());
        for (int c = 1; c <= n_ch; c++) begin
          if (c == bad_at) send_capture(STAMP_W'($urandom_range(0, 65535)));
          else send_capture(window_gap());
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) == 0) send_capture(STAMP_W'($urandom_range(0, 65535)));
          else send_read();
        end
      end
    end
  endtask

  // Drops valid, lets every pending result come back, then waits out the
  // pipeline so the block is idle before thresholds change or the run ends.
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One APB write: setup cycle, then access cycle; the register takes the
  // data at the edge that ends the access. Back-to-back writes chain the
  // next setup straight onto that edge, so psel is left high here.
  task automatic write_reg(input ppmfd_reg_e idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_SYNC_GAP_MIN: thresholds.sync_gap_min = value[STAMP_W-1:0];
      REG_PULSE_MIN:    thresholds.pulse_min    = value[STAMP_W-1:0];
      REG_PULSE_MAX:    thresholds.pulse_max    = value[STAMP_W-1:0];
      REG_OUT_LOW:      thresholds.out_low      = value[VALUE_W-1:0];
      REG_OUT_HIGH:     thresholds.out_high     = value[VALUE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_thresholds(input logic [STAMP_W-1:0] sync_min,
                                input logic [STAMP_W-1:0] pmin,
                                input logic [STAMP_W-1:0] pmax,
                                input logic [VALUE_W-1:0] lo,
                                input logic [VALUE_W-1:0] hi);
    write_reg(REG_SYNC_GAP_MIN, APB_DATA_W'(sync_min));
    write_reg(REG_PULSE_MIN, APB_DATA_W'(pmin));
    write_reg(REG_PULSE_MAX, APB_DATA_W'(pmax));
    write_reg(REG_OUT_LOW, APB_DATA_W'(lo));
    write_reg(REG_OUT_HIGH, APB_DATA_W'(hi));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    logic [STAMP_W-1:0] pmin;
    logic [VALUE_W-1:0] lo;
    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_valid_i     <= 1'b0;
    kind_i         <= KIND_CAPTURE;
    capture_time_i <= '0;
    read_channel_i <= '0;
    out_stall_i    <= 1'b0;
    beat_typed     <= 1'b0;
    beat_typed_res <= '0;
    thresholds   = '{SYNC_GAP_MIN_RST, PULSE_MIN_RST, PULSE_MAX_RST, OUT_LOW_RST, OUT_HIGH_RST};
    prev_stamp   = '0;
    frame_pos    = '0;
    link_good    = 1'b0;
    for (int i = 1; i <= NUM_CH; i++) width_store[i] = '0;
    stamp_now    = '0;
    beats_sent   = 0;
    quiet_cycles = 0;
    hold_off     = 0;
    no_idle      = 1'b0;
    failed       = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table on reset thresholds.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_beat(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].stamp, DIRECTED_ROWS[i].chan,
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
      if (DIRECTED_ROWS[i].kind == KIND_CAPTURE) stamp_now = DIRECTED_ROWS[i].stamp;
    end

    // Reset values written back explicitly; halfway through, the receiver
    // holds off long enough for the block to stall its input.
    settle_idle();
    set_thresholds(16'd20000, 16'd3000, 16'd9000, 14'd1000, 14'd2000);
    run_traffic(150);
    hold_off = HOLD_OFF_CYCLES;
    run_traffic(150);

    // Widest settings: no gap can be a sync, every gap but the two ends of
    // the range is in the window, and the clamps span the whole output.
    settle_idle();
    set_thresholds(16'hFFFF, 16'h0000, 16'hFFFF, 14'h0000, 14'h3FFF);
    run_traffic(250);

    // Closed settings: any nonzero gap is a sync, the window is empty, and
    // the clamps are crossed at their extremes.
    settle_idle();
    set_thresholds(16'h0000, 16'hFFFF, 16'h0000, 14'h3FFF, 14'h0000);
    run_traffic(150);

    // Mildly crossed clamps, with both sides running flat out.
    settle_idle();
    no_idle = 1'b1;
    set_thresholds(16'd30000, 16'd2000, 16'd12000, 14'd1800, 14'd1200);
    run_traffic(300);
    no_idle = 1'b0;

    // A few random threshold sets.
    repeat (4) begin
      settle_idle();
      pmin = STAMP_W'($urandom_range(0, 6000));
      lo   = VALUE_W'($urandom_range(0, 2500));
      set_thresholds(STAMP_W'($urandom_range(9000, 65535)), pmin,
                     STAMP_W'(pmin + $urandom_range(2, 15000)), lo,
                     VALUE_W'($urandom_range(0, 4000)));
      run_traffic(200);
    end

    settle_idle();
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
